// ===== rtl/cbr_pkg.sv =====
package cbr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned PREC_W = 3;
  localparam int unsigned TOL_W  = FRAC_W + 1;
  // multiplier operand: one guard bit over the word
  localparam int unsigned OP_W   = WORD_W + 1;
  localparam int unsigned PROD_W = 2 * OP_W;
  localparam int unsigned G1_W   = 2 * WORD_W + 1;
  localparam int unsigned ACC_W  = 3 * WORD_W + 4;

  // polynomial coefficients scaled to the Horner stage they join
  localparam logic [OP_W-1:0]  C6_G0  = OP_W'(6) << FRAC_W;
  localparam logic [G1_W-1:0]  C11_G1 = G1_W'(11) << (2 * FRAC_W);
  localparam logic [ACC_W-1:0] C6_ACC = ACC_W'(6) << (3 * FRAC_W);

  typedef struct packed {
    logic signed [WORD_W-1:0] interval_low;
    logic signed [WORD_W-1:0] interval_high;
    logic [PREC_W-1:0]        precision_digits;
  } cbr_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] root_estimate;
    logic                     no_sign_change;
  } cbr_out_t;

  typedef struct packed {
    logic done;
    logic neg;
    logic zero;
  } cbr_sign_t;

  // round(2^24 / 10^e), never below one lsb
  function automatic logic [TOL_W-1:0] tol_lsb(input logic [PREC_W-1:0] e);
    logic [TOL_W-1:0] t;
    unique case (e)
      3'd0:    t = TOL_W'(16777216);
      3'd1:    t = TOL_W'(1677722);
      3'd2:    t = TOL_W'(167772);
      3'd3:    t = TOL_W'(16777);
      3'd4:    t = TOL_W'(1678);
      3'd5:    t = TOL_W'(168);
      3'd6:    t = TOL_W'(17);
      default: t = TOL_W'(2);
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/cbr_eval.sv =====
module cbr_eval (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [cbr_pkg::WORD_W-1:0] x_i,
  output cbr_pkg::cbr_sign_t               sign_o
);
  import cbr_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE, E_MUL0, E_G1, E_LOW, E_HIGH, E_SUM
  } ev_state_e;

  ev_state_e               state_q;
  logic signed [OP_W-1:0]  op_a_q, op_b_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [G1_W-1:0]         g1;
  logic [OP_W-1:0]         g1_hi_q;
  logic [ACC_W-1:0]        acc_q;
  logic                    done_q;
  logic [OP_W-1:0]         x_ext;

  assign x_ext = {x_i[WORD_W-1], x_i};
  assign g1    = prod_q[G1_W-1:0] + C11_G1;

  // shared multiplier, registered every cycle
  always_ff @(posedge clk_i) begin
    prod_q <= op_a_q * op_b_q;
  end

  // 2^72 f(x) by horner: (-x + 6) * x + 11, then * x + 6, last step split in two limbs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      done_q  <= 1'b0;
      op_a_q  <= '0;
      op_b_q  <= '0;
      g1_hi_q <= '0;
      acc_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        E_IDLE: begin
          if (start_i) begin
            op_a_q  <= C6_G0 - x_ext;
            op_b_q  <= x_ext;
            state_q <= E_MUL0;
          end
        end
        E_MUL0: state_q <= E_G1;
        E_G1: begin
          op_a_q  <= {1'b0, g1[WORD_W-1:0]};
          g1_hi_q <= g1[G1_W-1:WORD_W];
          state_q <= E_LOW;
        end
        E_LOW: begin
          op_a_q  <= g1_hi_q;
          state_q <= E_HIGH;
        end
        E_HIGH: begin
          acc_q   <= {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q} + C6_ACC;
          state_q <= E_SUM;
        end
        E_SUM: begin
          acc_q   <= acc_q + {{(ACC_W-PROD_W-WORD_W){prod_q[PROD_W-1]}}, prod_q,
                              {WORD_W{1'b0}}};
          done_q  <= 1'b1;
          state_q <= E_IDLE;
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  assign sign_o.done = done_q;
  assign sign_o.neg  = acc_q[ACC_W-1];
  assign sign_o.zero = (acc_q == '0);

endmodule

// ===== rtl/cubic_bisection_root_top.sv =====
// sequence: the two endpoint evaluations, then, when their signs differ, one midpoint evaluation
// per halving (up to 32 halvings) until the width is within tolerance, then the result is registered
// one request at a time; the next is taken the cycle after the result is registered
// the single 33x33 multiplier is used three times per cubic evaluation
// reset: asynchronous, active low; clears the sequencer and the output valid
module cubic_bisection_root_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cbr_pkg::cbr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cbr_pkg::cbr_out_t out_data_o
);
  import cbr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FA, S_FB, S_MID, S_FM, S_FIN
  } state_e;

  state_e                    state_q;
  logic signed [WORD_W-1:0]  a_q, b_q, mid_q;
  logic [WORD_W-1:0]         rem_q;
  logic [TOL_W-1:0]          tol_q;
  logic                      fa_neg_q, fa_pos_q, opposite_q;
  logic                      out_valid_q;
  cbr_out_t                  out_q;

  logic                      in_accept, out_free;
  logic                      ev_start;
  logic signed [WORD_W-1:0]  ev_x;
  cbr_sign_t                 ev_sign;
  logic [WORD_W:0]           span, mid_sum;
  logic signed [WORD_W-1:0]  mid;
  logic                      fb_pos;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign span = {in_data_i.interval_high[WORD_W-1], in_data_i.interval_high}
              - {in_data_i.interval_low[WORD_W-1], in_data_i.interval_low};
  // floor of the exact half sum
  assign mid_sum = {a_q[WORD_W-1], a_q} + {b_q[WORD_W-1], b_q};
  assign mid     = mid_sum[WORD_W:1];
  assign fb_pos  = !ev_sign.neg && !ev_sign.zero;

  always_comb begin
    ev_start = 1'b0;
    ev_x     = mid;
    unique case (state_q)
      S_IDLE: begin
        ev_start = in_accept;
        ev_x     = in_data_i.interval_low;
      end
      S_FA: begin
        ev_start = ev_sign.done;
        ev_x     = b_q;
      end
      S_MID:   ev_start = opposite_q;
      default: ev_start = 1'b0;
    endcase
  end

  cbr_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ev_start),
    .x_i     (ev_x),
    .sign_o  (ev_sign)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      mid_q       <= '0;
      rem_q       <= '0;
      tol_q       <= '0;
      fa_neg_q    <= 1'b0;
      fa_pos_q    <= 1'b0;
      opposite_q  <= 1'b0;
    end else begin
      // a new result in the output stage takes over the slot being drained
      if (out_valid_q && !out_stall_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            a_q   <= in_data_i.interval_low;
            b_q   <= in_data_i.interval_high;
            tol_q <= tol_lsb(in_data_i.precision_digits);
            // a reversed or empty interval gets at most a single halving
            rem_q <= (in_data_i.interval_low < in_data_i.interval_high) ?
                     span[WORD_W-1:0] : '0;
            state_q <= S_FA;
          end
        end
        S_FA: begin
          if (ev_sign.done) begin
            fa_neg_q <= ev_sign.neg;
            fa_pos_q <= !ev_sign.neg && !ev_sign.zero;
            state_q  <= S_FB;
          end
        end
        S_FB: begin
          if (ev_sign.done) begin
            opposite_q <= (fa_neg_q && fb_pos) || (fa_pos_q && ev_sign.neg);
            state_q    <= S_MID;
          end
        end
        S_MID: begin
          mid_q   <= mid;
          state_q <= opposite_q ? S_FM : S_FIN;
        end
        S_FM: begin
          if (ev_sign.done) begin
            // exact zero at the midpoint keeps the interval
            if (!ev_sign.zero) begin
              if (ev_sign.neg == fa_neg_q) begin
                a_q <= mid_q;
              end else begin
                b_q <= mid_q;
              end
            end
            if (rem_q > WORD_W'(tol_q)) begin
              rem_q   <= (rem_q >> 1) + WORD_W'(rem_q[0]);
              state_q <= S_MID;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_q.root_estimate  <= mid_q;
            out_q.no_sign_change <= !opposite_q;
            out_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
